// ----- rtl/core/tppca_pkg.sv -----
// Package for the two-point pressure calibration core.
// Holds field widths, the calibration and window constants and the register indexes.
// Used by the core top level and the checker; it has no dependencies.
package tppca_pkg;

    localparam int WINDOW_LEN    = 10;
    localparam int SCALE_AT_SPAN = 400;

    localparam int ADC_W   = 10;
    localparam int DATA_W  = 16;
    localparam int SCALE_W = $clog2(SCALE_AT_SPAN + 1);
    localparam int NUM_W   = ADC_W + SCALE_W;
    localparam int CNT_W   = $clog2(NUM_W);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int SUM_W  = DATA_W + SLOT_W;
    localparam int MAG_W  = SUM_W - 1;

    // Division by the window length is done as a multiplication by a rounded-up
    // reciprocal; the shift is large enough that the result is exact over the sum range.
    localparam int RECIP_SHIFT = MAG_W + SLOT_W;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int RECIP_W     = RECIP_SHIFT - SLOT_W + 1;
    localparam int MUL_W       = MAG_W + RECIP_W;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_POINT = 1'b1;

    localparam logic [ADC_W-1:0] ZERO_POINT_RST = 10'd0;
    localparam logic [ADC_W-1:0] SPAN_POINT_RST = 10'd1023;

endpackage

// ----- rtl/core/tppca_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the sample window of the calibration core; no dependencies.
module tppca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/two_point_pressure_cal_avg_core.sv -----
// Top level of the two-point pressure calibration core with a moving average.
// Depends on tppca_pkg and on tppca_ram for the sample window.
//
// Usage:
// The s_ channel carries one converter sample per transaction; the m_ channel
// returns one result per sample: the calibrated pressure in tenths of cmH2O,
// the mean of the last WINDOW_LEN calibrated values, the raw sample and an
// error flag that is set when the span point equals the zero point.
// Calibration points are written through cfg_wr_en, cfg_index and cfg_wdata
// while no transaction is in flight.
// Processing: an accepted sample passes through a one-bit-per-cycle restoring
// divider, then window update, reciprocal multiply and output load, which
// sets m_valid. A new sample is taken only after the previous one has been
// loaded into the output register.
// The result sits in an output register, so the next sample is accepted while
// a result waits; if the receiver still stalls when the following result is
// ready, the core holds that result and does not return to accepting samples.
// Reset clears the window to zero through per-entry valid bits, so there is no
// clearing pass; the calibration points return to 0 and 1023.
module two_point_pressure_cal_avg_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [tppca_pkg::ADC_W-1:0]            s_adc_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [tppca_pkg::DATA_W-1:0]    m_pressure,
    output logic signed [tppca_pkg::DATA_W-1:0]    m_filtered_pressure,
    output logic [tppca_pkg::ADC_W-1:0]            m_raw_echo,
    output logic                                   m_cal_error,
    input  logic                                   cfg_wr_en,
    input  logic [tppca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tppca_pkg::ADC_W-1:0]            cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_FIN  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [tppca_pkg::ADC_W-1:0]        zero_point_reg, zero_point_next;
    logic [tppca_pkg::ADC_W-1:0]        span_point_reg, span_point_next;
    logic [tppca_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [tppca_pkg::WINDOW_LEN-1:0]   slot_valid_reg, slot_valid_next;
    logic signed [tppca_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                               m_valid_reg, m_valid_next;
    logic [tppca_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    logic [tppca_pkg::ADC_W-1:0]         sample_reg, sample_next;
    logic                                err_reg, err_next;
    logic                                qneg_reg, qneg_next;
    logic                                old_valid_reg, old_valid_next;
    logic [tppca_pkg::ADC_W-1:0]         den_mag_reg, den_mag_next;
    logic [tppca_pkg::ADC_W-1:0]         rem_reg, rem_next;
    logic [tppca_pkg::NUM_W-1:0]         quo_reg, quo_next;
    logic signed [tppca_pkg::DATA_W-1:0] press_reg, press_next;
    logic                                sum_neg_reg, sum_neg_next;
    logic [tppca_pkg::MUL_W-1:0]         mul_reg, mul_next;
    logic signed [tppca_pkg::DATA_W-1:0] out_press_reg, out_press_next;
    logic signed [tppca_pkg::DATA_W-1:0] out_mean_reg, out_mean_next;
    logic [tppca_pkg::ADC_W-1:0]         out_raw_reg, out_raw_next;
    logic                                out_err_reg, out_err_next;

    logic                                s_accept;
    logic                                out_free;
    logic signed [tppca_pkg::ADC_W:0]    num_diff;
    logic signed [tppca_pkg::ADC_W:0]    den_diff;
    logic [tppca_pkg::ADC_W:0]           num_abs;
    logic [tppca_pkg::ADC_W:0]           den_abs;
    logic [tppca_pkg::NUM_W-1:0]         num_mag;
    logic [tppca_pkg::ADC_W:0]           trial;
    logic [tppca_pkg::ADC_W+1:0]         trial_diff;
    logic                                trial_ge;
    logic signed [tppca_pkg::DATA_W-1:0] press_c;
    logic signed [tppca_pkg::DATA_W-1:0] old_c;
    logic [tppca_pkg::SUM_W-1:0]         sum_abs;
    logic [tppca_pkg::DATA_W-1:0]        mean_mag;

    logic                                ram_wr_en;
    logic                                ram_rd_en;
    logic [tppca_pkg::DATA_W-1:0]        ram_rd_data;

    tppca_ram #(
        .WIDTH(tppca_pkg::DATA_W),
        .DEPTH(tppca_pkg::WINDOW_LEN)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (press_c),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign num_diff = $signed({1'b0, s_adc_sample}) - $signed({1'b0, zero_point_reg});
    assign den_diff = $signed({1'b0, span_point_reg}) - $signed({1'b0, zero_point_reg});
    assign num_abs  = num_diff[tppca_pkg::ADC_W] ? (~num_diff + 1'b1) : num_diff;
    assign den_abs  = den_diff[tppca_pkg::ADC_W] ? (~den_diff + 1'b1) : den_diff;
    assign num_mag  = tppca_pkg::NUM_W'(num_abs[tppca_pkg::ADC_W-1:0])
                    * tppca_pkg::NUM_W'(tppca_pkg::SCALE_AT_SPAN);

    assign trial      = {rem_reg, quo_reg[tppca_pkg::NUM_W-1]};
    assign trial_diff = {1'b0, trial} - {2'b00, den_mag_reg};
    assign trial_ge   = !trial_diff[tppca_pkg::ADC_W+1];

    always_comb begin
        if (err_reg) begin
            press_c = '0;
        end else if (!qneg_reg) begin
            press_c = (quo_reg > tppca_pkg::NUM_W'(32767)) ? 16'sh7FFF
                                                            : $signed(quo_reg[15:0]);
        end else begin
            press_c = (quo_reg > tppca_pkg::NUM_W'(32768)) ? 16'sh8000
                                                            : $signed(~quo_reg[15:0] + 16'd1);
        end
    end

    assign old_c    = old_valid_reg ? $signed(ram_rd_data) : '0;
    assign sum_abs  = sum_reg[tppca_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign mean_mag = mul_reg[tppca_pkg::RECIP_SHIFT +: tppca_pkg::DATA_W];

    assign ram_rd_en = s_accept;
    assign ram_wr_en = (state_reg == ST_FIN);

    always_comb begin
        state_next      = state_reg;
        zero_point_next = zero_point_reg;
        span_point_next = span_point_reg;
        slot_next       = slot_reg;
        slot_valid_next = slot_valid_reg;
        sum_next        = sum_reg;
        m_valid_next    = m_valid_reg;
        cnt_next        = cnt_reg;
        sample_next     = sample_reg;
        err_next        = err_reg;
        qneg_next       = qneg_reg;
        old_valid_next  = old_valid_reg;
        den_mag_next    = den_mag_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        press_next      = press_reg;
        sum_neg_next    = sum_neg_reg;
        mul_next        = mul_reg;
        out_press_next  = out_press_reg;
        out_mean_next   = out_mean_reg;
        out_raw_next    = out_raw_reg;
        out_err_next    = out_err_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                tppca_pkg::CFG_ZERO_POINT: zero_point_next = cfg_wdata;
                tppca_pkg::CFG_SPAN_POINT: span_point_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sample_next    = s_adc_sample;
                    err_next       = (span_point_reg == zero_point_reg);
                    qneg_next      = num_diff[tppca_pkg::ADC_W] ^ den_diff[tppca_pkg::ADC_W];
                    den_mag_next   = den_abs[tppca_pkg::ADC_W-1:0];
                    quo_next       = num_mag;
                    rem_next       = '0;
                    cnt_next       = '0;
                    old_valid_next = slot_valid_reg[slot_reg];
                    state_next     = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = trial_ge ? trial_diff[tppca_pkg::ADC_W-1:0]
                                    : trial[tppca_pkg::ADC_W-1:0];
                quo_next = {quo_reg[tppca_pkg::NUM_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tppca_pkg::CNT_W'(tppca_pkg::NUM_W - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                press_next = press_c;
                sum_next   = sum_reg - tppca_pkg::SUM_W'(old_c) + tppca_pkg::SUM_W'(press_c);
                slot_valid_next[slot_reg] = 1'b1;
                slot_next  = (slot_reg == tppca_pkg::SLOT_W'(tppca_pkg::WINDOW_LEN - 1))
                           ? '0 : slot_reg + 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                sum_neg_next = sum_reg[tppca_pkg::SUM_W-1];
                mul_next     = tppca_pkg::MUL_W'(sum_abs[tppca_pkg::MAG_W-1:0])
                             * tppca_pkg::MUL_W'(tppca_pkg::RECIP);
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_press_next = press_reg;
                    out_mean_next  = sum_neg_reg ? $signed(~mean_mag + 16'd1)
                                                 : $signed(mean_mag);
                    out_raw_next   = sample_reg;
                    out_err_next   = err_reg;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            zero_point_reg <= tppca_pkg::ZERO_POINT_RST;
            span_point_reg <= tppca_pkg::SPAN_POINT_RST;
            slot_reg       <= '0;
            slot_valid_reg <= '0;
            sum_reg        <= '0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            zero_point_reg <= zero_point_next;
            span_point_reg <= span_point_next;
            slot_reg       <= slot_next;
            slot_valid_reg <= slot_valid_next;
            sum_reg        <= sum_next;
            m_valid_reg    <= m_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg    <= sample_next;
        err_reg       <= err_next;
        qneg_reg      <= qneg_next;
        old_valid_reg <= old_valid_next;
        den_mag_reg   <= den_mag_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        press_reg     <= press_next;
        sum_neg_reg   <= sum_neg_next;
        mul_reg       <= mul_next;
        out_press_reg <= out_press_next;
        out_mean_reg  <= out_mean_next;
        out_raw_reg   <= out_raw_next;
        out_err_reg   <= out_err_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_pressure          = out_press_reg;
    assign m_filtered_pressure = out_mean_reg;
    assign m_raw_echo          = out_raw_reg;
    assign m_cal_error         = out_err_reg;

endmodule

// ----- rtl/core/tppca_checker.sv -----
// Port-level assertions for the two-point pressure calibration core.
// Depends on tppca_pkg; bound to two_point_pressure_cal_avg_core at the end of this file.
module tppca_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [tppca_pkg::DATA_W-1:0] m_pressure,
    input logic signed [tppca_pkg::DATA_W-1:0] m_filtered_pressure,
    input logic [tppca_pkg::ADC_W-1:0]         m_raw_echo,
    input logic                                m_cal_error
);

    // A stalled result keeps its whole payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressure)
            && $stable(m_filtered_pressure) && $stable(m_raw_echo) && $stable(m_cal_error))
        else $error("result changed while stalled");

    // The core works on one sample at a time, so it is busy right after a transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // A calibration error always reports zero pressure.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cal_error |-> m_pressure == '0)
        else $error("calibration error with nonzero pressure");

    // No result is presented in the cycle after reset.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind two_point_pressure_cal_avg_core tppca_checker u_tppca_checker (.*);

// ----- verif/tb_two_point_pressure_cal_avg_core.sv -----
// Testbench for two_point_pressure_cal_avg_core: drives converter samples and
// calibration writes, predicts every result and checks each output transaction.
// Depends on tppca_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_two_point_pressure_cal_avg_core;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int IDLE_TAIL    = 40;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 125;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic signed [tppca_pkg::DATA_W-1:0] pressure;
        logic signed [tppca_pkg::DATA_W-1:0] filtered;
        logic [tppca_pkg::ADC_W-1:0]         raw;
        logic                                cal_error;
    } cal_result_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PERIODIC
    } rdy_mode_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [tppca_pkg::ADC_W-1:0]         s_adc_sample = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [tppca_pkg::DATA_W-1:0] m_pressure;
    logic signed [tppca_pkg::DATA_W-1:0] m_filtered_pressure;
    logic [tppca_pkg::ADC_W-1:0]         m_raw_echo;
    logic                                m_cal_error;
    logic                                cfg_wr_en = 1'b0;
    logic [tppca_pkg::CFG_IDX_W-1:0]     cfg_index = tppca_pkg::CFG_ZERO_POINT;
    logic [tppca_pkg::ADC_W-1:0]         cfg_wdata = '0;

    logic [tppca_pkg::ADC_W-1:0]  cal_zero = tppca_pkg::ZERO_POINT_RST;
    logic [tppca_pkg::ADC_W-1:0]  cal_span = tppca_pkg::SPAN_POINT_RST;
    shortint           win_vals [tppca_pkg::WINDOW_LEN] = '{default: 0};
    int                win_slot = 0;
    int                win_sum = 0;

    cal_result_t       pending_results [$];
    int                fail_count = 0;
    int                cycle_count = 0;
    rdy_mode_t         rdy_mode = RDY_ALWAYS;
    int                rdy_left = 0;

    two_point_pressure_cal_avg_core uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_adc_sample        (s_adc_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pressure          (m_pressure),
        .m_filtered_pressure (m_filtered_pressure),
        .m_raw_echo          (m_raw_echo),
        .m_cal_error         (m_cal_error),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[two_point_pressure_cal_avg_core] ERROR");
            $finish;
        end
    end

    // The receiver changes its stall behavior at random intervals.
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode <= rdy_mode_t'($urandom_range(0, 3));
            rdy_left <= $urandom_range(50, 400);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY: m_ready <= ($urandom_range(0, 3) == 0);
            default:    m_ready <= ((cycle_count % 64) < 16);
        endcase
    end

    function automatic cal_result_t predict_sample(input logic [tppca_pkg::ADC_W-1:0] sample);
        cal_result_t r;
        longint num;
        longint den;
        longint quot;
        num = (longint'(sample) - longint'(cal_zero)) * tppca_pkg::SCALE_AT_SPAN;
        den = longint'(cal_span) - longint'(cal_zero);
        r.raw = sample;
        if (den == 0) begin
            r.pressure = '0;
            r.cal_error = 1'b1;
        end else begin
            quot = num / den;
            if (quot > 32767) begin
                r.pressure = 16'sh7FFF;
            end else if (quot < -32768) begin
                r.pressure = 16'sh8000;
            end else begin
                r.pressure = 16'(quot);
            end
            r.cal_error = 1'b0;
        end
        win_sum = win_sum - int'(win_vals[win_slot]) + int'(r.pressure);
        win_vals[win_slot] = r.pressure;
        win_slot = (win_slot == tppca_pkg::WINDOW_LEN - 1) ? 0 : win_slot + 1;
        r.filtered = 16'(win_sum / tppca_pkg::WINDOW_LEN);
        return r;
    endfunction

    function automatic logic [tppca_pkg::ADC_W-1:0] clamp_code(input int v);
        if (v < 0) begin
            return '0;
        end else if (v > 1023) begin
            return '1;
        end
        return v[tppca_pkg::ADC_W-1:0];
    endfunction

    function automatic logic [tppca_pkg::ADC_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return clamp_code(int'(cal_zero) + int'($urandom_range(0, 6)) - 3);
            3: return clamp_code(int'(cal_span) + int'($urandom_range(0, 6)) - 3);
            default: return tppca_pkg::ADC_W'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    always @(posedge aclk) begin
        cal_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_failure($sformatf("unexpected result transaction: raw %0d", m_raw_echo));
            end else begin
                want = pending_results.pop_front();
                if (m_pressure !== want.pressure || m_filtered_pressure !== want.filtered ||
                    m_raw_echo !== want.raw || m_cal_error !== want.cal_error) begin
                    report_failure($sformatf(
                        {"mismatch: expected p=%0d f=%0d raw=%0d err=%0b, ",
                         "got p=%0d f=%0d raw=%0d err=%0b"},
                        want.pressure, want.filtered, want.raw, want.cal_error,
                        m_pressure, m_filtered_pressure, m_raw_echo, m_cal_error));
                end
            end
        end
    end

    task automatic send_sample(input logic [tppca_pkg::ADC_W-1:0] sample);
        s_valid <= 1'b1;
        s_adc_sample <= sample;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_sample(sample));
    endtask

    task automatic settle(input int tail);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic set_calibration(input logic [tppca_pkg::ADC_W-1:0] zero,
                                   input logic [tppca_pkg::ADC_W-1:0] span);
        cfg_wr_en <= 1'b1;
        cfg_index <= tppca_pkg::CFG_ZERO_POINT;
        cfg_wdata <= zero;
        @(posedge aclk);
        cal_zero = zero;
        cfg_index <= tppca_pkg::CFG_SPAN_POINT;
        cfg_wdata <= span;
        @(posedge aclk);
        cal_span = span;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        send_sample('0);
        send_sample('1);
        send_sample(10'd511);
        settle(IDLE_TAIL);
    endtask

    task automatic test_code_extremes();
        set_calibration('0, '1);
        send_sample('0);
        send_sample('1);
        send_sample(10'h155);
        send_sample(10'h2AA);
        send_sample(10'd1);
        send_sample(10'd1022);
        settle(IDLE_TAIL);
    endtask

    task automatic test_zero_span();
        set_calibration(10'd500, 10'd500);
        send_sample('0);
        send_sample('1);
        send_sample(10'd500);
        settle(IDLE_TAIL);
        set_calibration('0, '0);
        send_sample('0);
        settle(IDLE_TAIL);
        set_calibration('1, '1);
        send_sample('1);
        settle(IDLE_TAIL);
    endtask

    task automatic test_saturation();
        set_calibration('0, 10'd1);
        send_sample('1);
        send_sample('0);
        settle(IDLE_TAIL);
        set_calibration(10'd1022, '1);
        send_sample('0);
        settle(IDLE_TAIL);
        set_calibration('1, 10'd1022);
        send_sample('0);
        settle(IDLE_TAIL);
    endtask

    task automatic test_inverted_span();
        set_calibration(10'd1000, 10'd100);
        send_sample('0);
        send_sample(10'd550);
        send_sample('1);
        settle(IDLE_TAIL);
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        int gap;
        int pause_at;
        bit steady;
        logic [tppca_pkg::ADC_W-1:0] zero;
        logic [tppca_pkg::ADC_W-1:0] span;
        for (int phase = 0; phase < PHASES; phase++) begin
            zero = tppca_pkg::ADC_W'($urandom_range(0, 1023));
            case ($urandom_range(0, 7))
                0: begin
                    zero = '0;
                    span = '1;
                end
                1: begin
                    zero = '1;
                    span = '0;
                end
                2: span = zero;
                3: begin
                    zero = '0;
                    span = 10'd1;
                end
                4: span = clamp_code(int'(zero) + ($urandom_range(0, 1) ? 1 : -1) *
                                     int'($urandom_range(1, 4)));
                default: span = tppca_pkg::ADC_W'($urandom_range(0, 1023));
            endcase
            set_calibration(zero, span);
            steady = (phase % 3 == 0);
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
                    send_sample(pick_sample());
                    sent++;
                    if (sent == pause_at) begin
                        settle(1);
                    end
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                if (!steady && gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            settle(IDLE_TAIL);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_reset_defaults();
        test_code_extremes();
        test_zero_span();
        test_saturation();
        test_inverted_span();
        test_random_traffic();
        settle(IDLE_TAIL);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("[two_point_pressure_cal_avg_core] OK");
        end else begin
            $display("[two_point_pressure_cal_avg_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- two_point_pressure_cal_avg_core.f -----
rtl/core/tppca_pkg.sv
rtl/core/tppca_ram.sv
rtl/core/two_point_pressure_cal_avg_core.sv
rtl/core/tppca_checker.sv
verif/tb_two_point_pressure_cal_avg_core.sv
